// ===== hw/rtl/dda_pkg.sv =====
package dda_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch deltas, start position, arm the line
    logic prep;      // abs deltas, step count, divider seed
    logic div_step;  // one restoring divide iteration on both axes
    logic sign;      // apply delta signs to the quotients
    logic tick;      // emit current pixel and advance
  } dda_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic out_busy;
  } dda_status_t;

endpackage

// ===== hw/rtl/dda_in_if.sv =====
interface dda_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

// ===== hw/rtl/dda_out_if.sv =====
interface dda_out_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== hw/rtl/dda_ctrl.sv =====
module dda_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  input  dda_pkg::dda_status_t status,
  output dda_pkg::dda_cmd_t    cmd
);
  import dda_pkg::*;

  localparam int ITERS = FRAC_BITS + 1;
  localparam int CW    = $clog2(ITERS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SIGN = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   iter;
  logic            accept;

  assign in_ready = (state == ST_IDLE) && !status.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept && !in_kind;
    cmd.tick     = accept && in_kind;
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.sign     = (state == ST_SIGN);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && !in_kind) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (iter == CW'(ITERS - 1)) state_next = ST_SIGN;
      ST_SIGN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) iter <= '0;
      else if (state == ST_DIV) iter <= iter + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_load_enters_prep: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_kind) |=> (state == ST_PREP))
    else $error("load beat did not start the divide");
  a_div_ends_in_sign: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && iter == CW'(ITERS - 1)) |=> (state == ST_SIGN))
    else $error("divide overran its iteration count");
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input taken while divide in progress");
`endif
endmodule

// ===== hw/rtl/dda_datapath.sv =====
module dda_datapath #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dda_pkg::dda_cmd_t     cmd,
  output dda_pkg::dda_status_t  status,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);
  import dda_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = C + F + 1;   // position
  localparam int SW = F + 2;       // increment
  localparam int NW = C + F + 1;   // dividend
  localparam int LW = C + 1;       // delta, pixel count

  logic signed [LW-1:0] dx, dy;
  logic [C-1:0]         steps_r;
  logic [C-1:0]         rem_x, rem_y;
  logic [F:0]           q_x, q_y;
  logic                 neg_x, neg_y;
  logic signed [PW-1:0] pos_x, pos_y;
  logic signed [SW-1:0] step_x, step_y;
  logic [LW-1:0]        pixels_left;
  logic                 active;

  // prep stage
  logic signed [LW-1:0] ndx, ndy;
  logic [C-1:0]         adx, ady, steps;
  logic [NW-1:0]        num_x, num_y;

  always_comb begin
    ndx   = -dx;
    ndy   = -dy;
    adx   = dx[LW-1] ? ndx[C-1:0] : dx[C-1:0];
    ady   = dy[LW-1] ? ndy[C-1:0] : dy[C-1:0];
    steps = (adx > ady) ? adx : ady;
    // |d| * 2^F + steps/2, rounds the quotient to nearest
    num_x = {1'b0, adx, F'(0)} + NW'(steps[C-1:1]);
    num_y = {1'b0, ady, F'(0)} + NW'(steps[C-1:1]);
  end

  // one restoring iteration per axis; remainder stays below steps
  logic [C:0] trial_x, trial_y, sub_x, sub_y;
  logic       ge_x, ge_y;

  always_comb begin
    trial_x = {rem_x, q_x[F]};
    trial_y = {rem_y, q_y[F]};
    ge_x    = trial_x >= {1'b0, steps_r};
    ge_y    = trial_y >= {1'b0, steps_r};
    sub_x   = trial_x - {1'b0, steps_r};
    sub_y   = trial_y - {1'b0, steps_r};
  end

  logic signed [SW-1:0] mag_x, mag_y;
  assign mag_x = signed'({1'b0, q_x});
  assign mag_y = signed'({1'b0, q_y});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx    <= signed'({1'b0, x_end}) - signed'({1'b0, x_start});
      dy    <= signed'({1'b0, y_end}) - signed'({1'b0, y_start});
      // start + one half; low fraction bits of start are zero
      pos_x <= signed'({1'b0, x_start, 1'b1, (F-1)'(0)});
      pos_y <= signed'({1'b0, y_start, 1'b1, (F-1)'(0)});
    end
    if (cmd.prep) begin
      steps_r <= steps;
      rem_x   <= num_x[NW-1:F+1];
      rem_y   <= num_y[NW-1:F+1];
      q_x     <= num_x[F:0];
      q_y     <= num_y[F:0];
      neg_x   <= dx[LW-1];
      neg_y   <= dy[LW-1];
    end
    if (cmd.div_step) begin
      rem_x <= ge_x ? sub_x[C-1:0] : trial_x[C-1:0];
      rem_y <= ge_y ? sub_y[C-1:0] : trial_y[C-1:0];
      q_x   <= {q_x[F-1:0], ge_x};
      q_y   <= {q_y[F-1:0], ge_y};
    end
    if (cmd.sign) begin
      // zero-length line: divisor was zero, quotient is junk
      if (steps_r == '0) begin
        step_x <= '0;
        step_y <= '0;
      end else begin
        step_x <= neg_x ? -mag_x : mag_x;
        step_y <= neg_y ? -mag_y : mag_y;
      end
    end
    if (cmd.tick && active) begin
      pixel_x <= pos_x[F+C-1:F];
      pixel_y <= pos_y[F+C-1:F];
      last    <= (pixels_left == LW'(1));
      pos_x   <= pos_x + PW'(step_x);
      pos_y   <= pos_y + PW'(step_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixels_left <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) active <= 1'b1;
      if (cmd.prep) pixels_left <= {1'b0, steps} + LW'(1);
      if (cmd.tick && active) begin
        pixels_left <= pixels_left - LW'(1);
        active      <= (pixels_left != LW'(1));
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  localparam logic signed [SW-1:0] OneFix = SW'(1) <<< F;
  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    (active && !cmd.prep) |-> (pixels_left != '0))
    else $error("active line with no pixels left");
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && active && pixels_left == LW'(1)) |=> (!active && out_valid && last))
    else $error("endpoint beat did not close the line");
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.sign |=> (step_x <= OneFix && step_x >= -OneFix &&
                  step_y <= OneFix && step_y >= -OneFix))
    else $error("increment exceeds one pixel");
`endif
endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
// DDA line rasterizer.
// in_ch carries one beat per command. kind = 0 loads a line from
// (x_start, y_start) to (x_end, y_end); kind = 1 is a tick that asks for
// the next pixel. out_ch carries pixel_x, pixel_y and last, which marks
// the line endpoint. A line of n = max(|dx|, |dy|) steps yields n + 1
// pixels; a zero-length line yields its start point alone.
// A load holds off the input after its beat until its increments are set:
// a setup state, FRAC_BITS + 1 iterations of the two-lane restoring
// divider that forms the increments, then a sign state. Ticks are taken one
// per cycle while out_ch is not stalled; a pixel appears on out_ch the
// cycle after its tick. Ticks with no line loaded, or after the endpoint,
// are consumed and give nothing. A load replaces any line in progress.
// The result sits in an output register; while the receiver stalls with
// a pixel pending, in_ch is held not ready. Reset (synchronous, active
// high) drops the current line and empties the output register.
module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch
);
  import dda_pkg::*;

  dda_cmd_t    cmd;
  dda_status_t status;

  dda_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dda_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .x_start   (in_ch.x_start),
    .y_start   (in_ch.y_start),
    .x_end     (in_ch.x_end),
    .y_end     (in_ch.y_end),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .pixel_x   (out_ch.pixel_x),
    .pixel_y   (out_ch.pixel_y),
    .last      (out_ch.last)
  );
endmodule
